/* hw/rtl/optr_pkg.sv */
// Shared types and constants for the olive phenology phase tracker.
// Used by optr_ctrl, optr_dp and olive_phenology_phase_tracker; no dependencies.
package optr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PHASE_W   = 19;
   localparam int NUM_W     = 36;
   localparam int DEN_W     = 28;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W     = 6;
   localparam int IDX_W     = 8;

   localparam logic [IDX_W-1:0] REG_START_DAY = 8'd0;
   localparam logic [IDX_W-1:0] REG_FLOWER_DD = 8'd1;
   localparam logic [IDX_W-1:0] REG_RIPEN_DD  = 8'd2;
   localparam logic [IDX_W-1:0] REG_BBCH_EN   = 8'd3;

   localparam logic [15:0] START_DAY_RST = 16'd0;
   localparam logic [15:0] DD_LIMIT_RST  = 16'd1000;

   localparam logic [2:0] STG_DORMANT   = 3'd0;
   localparam logic [2:0] STG_INDUCTION = 3'd1;
   localparam logic [2:0] STG_FLOWERING = 3'd2;
   localparam logic [2:0] STG_RIPENING  = 3'd3;
   localparam logic [2:0] STG_MATURE    = 3'd4;

   localparam logic [2:0] EVT_NONE  = 3'd0;
   localparam logic [2:0] EVT_START = 3'd1;

   localparam logic [14:0] BBCH_FLOWER_BASE = 15'd2304;
   localparam logic [14:0] BBCH_RIPEN_BASE  = 15'd16640;
   localparam logic [14:0] BBCH_MATURE      = 15'd22784;

   typedef struct packed {
      logic [15:0] start_day;
      logic [15:0] flower_dd;
      logic [15:0] ripen_dd;
      logic        bbch_en;
   } optr_cfg_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mult;
      logic div_init;
      logic div_step;
      logic commit;
   } optr_cmd_type;

   typedef struct packed {
      logic div_last;
   } optr_sts_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP   = 6'b000010,
      ST_MULT   = 6'b000100,
      ST_DINIT  = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_COMMIT = 6'b100000
   } optr_state_type;

endpackage

/* hw/rtl/optr_ctrl.sv */
// Sequencer for the phase tracker: request intake, division steps, result slot.
// Depends on optr_pkg.
module optr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output optr_pkg::optr_cmd_type cmd,
   input  optr_pkg::optr_sts_type sts
);

   optr_pkg::optr_state_type state_ff, state_in;
   logic out_full_ff, out_full_in;
   logic slot_free;

   assign slot_free  = !out_full_ff || rsp_tready;
   assign req_tready = (state_ff == optr_pkg::ST_IDLE) && !reset;
   assign rsp_tvalid = out_full_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         optr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = optr_pkg::ST_PREP;
            end
         end
         optr_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = optr_pkg::ST_MULT;
         end
         optr_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = optr_pkg::ST_DINIT;
         end
         optr_pkg::ST_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = optr_pkg::ST_DIV;
         end
         optr_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = optr_pkg::ST_COMMIT;
            end
         end
         optr_pkg::ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = optr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = optr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_full_in = out_full_ff;
      if (rsp_tready) begin
         out_full_in = 1'b0;
      end
      if (cmd.commit) begin
         out_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= optr_pkg::ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

endmodule

/* hw/rtl/optr_dp.sv */
// Datapath of the phase tracker: operand set-up, products, shared restoring
// divider, phase accumulator, BBCH mapping and result register. Depends on optr_pkg.
module optr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  optr_pkg::optr_cfg_type cfg,
   input  optr_pkg::optr_cmd_type cmd,
   output optr_pkg::optr_sts_type sts,
   input  logic [15:0]            day_number,
   input  logic signed [10:0]     min_temp,
   input  logic signed [10:0]     max_temp,
   input  logic                   temp_missing,
   output logic [18:0]            phase_value,
   output logic [2:0]             stage,
   output logic [2:0]             transition_event,
   output logic [14:0]            bbch_value,
   output logic                   bbch_valid,
   output logic                   missing_status
);

   localparam logic [1:0] K_NONE   = 2'd0;
   localparam logic [1:0] K_INDUCT = 2'd1;
   localparam logic [1:0] K_WARM   = 2'd2;
   localparam logic [1:0] K_TRI    = 2'd3;
   localparam logic [optr_pkg::DEN_W-1:0] INDUCT_DIV = 28'd850;

   // request capture
   logic [15:0]        day_ff;
   logic signed [10:0] tn_ff, tx_ff;
   logic               miss_ff;

   // operand set-up
   logic signed [11:0] s_c, a_c, d_c, sd_c;
   logic [5:0]         n_c;
   logic [1:0]         kind_c;
   logic [2:0]         cur_stg;
   logic [15:0]        lim_c;
   logic [1:0]         kind_ff;
   logic [5:0]         n_ff;
   logic [10:0]        sd_ff;
   logic [9:0]         a_ff;
   logic [10:0]        d_ff;
   logic [15:0]        lim_ff;

   // products
   logic [19:0] sq_ff;
   logic [26:0] dl_ff;

   // divider
   logic [optr_pkg::NUM_W-1:0] num_ff, num_in;
   logic [optr_pkg::DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [optr_pkg::DEN_W:0]   rem_sh, rem_diff;
   logic [optr_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // accumulator and result
   logic [optr_pkg::PHASE_W-1:0] acc_ff, acc_in;
   logic [36:0]                  sum_c, cap_c;
   logic [2:0]                   evt_c, new_stg;
   logic [15:0]                  frac_c;
   logic [19:0]                  m9;
   logic [20:0]                  m24;
   logic [21:0]                  m56;
   logic [14:0]                  bbch_c;
   logic                         bbch_v_c;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff  <= day_number;
         tn_ff   <= min_temp;
         tx_ff   <= max_temp;
         miss_ff <= temp_missing;
      end
   end

   always_comb begin
      s_c     = {tn_ff[10], tn_ff} + {tx_ff[10], tx_ff};
      a_c     = {tx_ff[10], tx_ff} - 12'sd125;
      d_c     = {tx_ff[10], tx_ff} - {tn_ff[10], tn_ff};
      sd_c    = s_c - 12'sd250;
      cur_stg = acc_ff[18:16];
      lim_c   = (cur_stg == optr_pkg::STG_FLOWERING) ? cfg.flower_dd : cfg.ripen_dd;
      if (lim_c == 16'd0) begin
         lim_c = 16'd1;
      end
      n_c = 6'd0;
      if (s_c >= 12'sd244 && s_c <= 12'sd266) begin
         n_c = 6'd50;
      end else if (s_c >= 12'sd194 && s_c < 12'sd244 && tx_ff >= 11'sd125) begin
         n_c = 6'(s_c - 12'sd194);
      end else if (s_c > 12'sd266 && s_c <= 12'sd316 && tx_ff <= 11'sd211) begin
         n_c = 6'(s_c - 12'sd266);
      end
      kind_c = K_NONE;
      if (cur_stg == optr_pkg::STG_INDUCTION) begin
         kind_c = K_INDUCT;
      end else if (cur_stg == optr_pkg::STG_FLOWERING || cur_stg == optr_pkg::STG_RIPENING) begin
         if (s_c > 12'sd250) begin
            kind_c = K_WARM;
         end else if (tx_ff > 11'sd125) begin
            kind_c = K_TRI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         kind_ff <= kind_c;
         n_ff    <= n_c;
         sd_ff   <= sd_c[10:0];
         a_ff    <= a_c[9:0];
         d_ff    <= d_c[10:0];
         lim_ff  <= lim_c;
      end
      if (cmd.mult) begin
         sq_ff <= 20'(a_ff) * 20'(a_ff);
         dl_ff <= 27'(d_ff) * 27'(lim_ff);
      end
   end

   // restoring division, one quotient bit a cycle; quotient bits replace numerator bits
   always_comb begin
      rem_sh   = {rem_ff, num_ff[optr_pkg::NUM_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (cmd.div_init) begin
         rem_in = '0;
         cnt_in = '0;
         case (kind_ff)
            K_INDUCT: begin
               num_in = {14'd0, n_ff, 16'd0};
               den_in = INDUCT_DIV;
            end
            K_WARM: begin
               num_in = {9'd0, sd_ff, 16'd0};
               den_in = {11'd0, lim_ff, 1'b0};
            end
            K_TRI: begin
               num_in = {sq_ff, 16'd0};
               den_in = {dl_ff, 1'b0};
            end
            default: begin
               num_in = '0;
               den_in = INDUCT_DIV;
            end
         endcase
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 6'd1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_diff[optr_pkg::DEN_W-1:0];
            num_in = {num_ff[optr_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[optr_pkg::DEN_W-1:0];
            num_in = {num_ff[optr_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign sts.div_last = (cnt_ff == 6'(optr_pkg::DIV_STEPS - 1));

   always_comb begin
      acc_in = acc_ff;
      evt_c  = optr_pkg::EVT_NONE;
      sum_c  = {18'd0, acc_ff} + {1'b0, num_ff};
      cap_c  = {18'd0, 3'(cur_stg + 3'd1), 16'd0};
      if (!miss_ff) begin
         case (cur_stg)
            optr_pkg::STG_DORMANT: begin
               if (day_ff == cfg.start_day) begin
                  acc_in = {3'd1, 16'd0};
                  evt_c  = optr_pkg::EVT_START;
               end
            end
            optr_pkg::STG_INDUCTION, optr_pkg::STG_FLOWERING, optr_pkg::STG_RIPENING: begin
               if (sum_c >= cap_c) begin
                  acc_in = cap_c[18:0];
                  evt_c  = 3'(cur_stg + 3'd1);
               end else begin
                  acc_in = sum_c[18:0];
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
      new_stg  = acc_in[18:16];
      frac_c   = acc_in[15:0];
      m9       = 20'(frac_c) * 20'd9;
      m24      = 21'(frac_c) * 21'd24;
      m56      = 22'(frac_c) * 22'd56;
      bbch_c   = '0;
      bbch_v_c = 1'b0;
      if (cfg.bbch_en) begin
         case (new_stg)
            optr_pkg::STG_INDUCTION: begin
               bbch_v_c = 1'b1;
               bbch_c   = {3'd0, m9[19:8]};
            end
            optr_pkg::STG_FLOWERING: begin
               bbch_v_c = 1'b1;
               bbch_c   = optr_pkg::BBCH_FLOWER_BASE + {1'b0, m56[21:8]};
            end
            optr_pkg::STG_RIPENING: begin
               bbch_v_c = 1'b1;
               bbch_c   = optr_pkg::BBCH_RIPEN_BASE + {2'd0, m24[20:8]};
            end
            optr_pkg::STG_MATURE: begin
               bbch_v_c = 1'b1;
               bbch_c   = optr_pkg::BBCH_MATURE;
            end
            default: begin
               bbch_v_c = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.commit) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         phase_value      <= acc_in;
         stage            <= new_stg;
         transition_event <= evt_c;
         bbch_value       <= bbch_c;
         bbch_valid       <= bbch_v_c;
         missing_status   <= miss_ff;
      end
   end

endmodule

/* hw/rtl/olive_phenology_phase_tracker.sv */
// Olive phenology phase tracker, top level: register file and channel packing.
// Depends on optr_pkg, optr_ctrl and optr_dp.
//
// Usage:
//  - req_ channel takes one daily record per request; csr_ channel writes the
//    start day, the two degree-day limits and the BBCH enable by index 0 to 3
//    (other indexes are ignored). csr_ready is high out of reset; write only while idle.
//  - rsp_ channel returns exactly one result per request, in order.
//  - A request is taken only when the block is idle. After the accepting edge it goes
//    through operand set-up, one product stage, divider load, 36 steps of the shared
//    restoring divider and a commit step, which raises rsp_tvalid. The next request is
//    taken only after that commit, so requests are not overlapped.
//  - A stalled result is held in the output register; the next request is
//    taken and worked on meanwhile, and waits at commit until the slot frees.
//  - Reset clears the phase to 0 (dormant) and the registers to start day 0,
//    limits 1000 and BBCH disabled; no clearing pass is needed.
module olive_phenology_phase_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // day_number[15:0], min_temp[26:16], max_temp[37:27], zero pad
   input  logic [0:0]  req_tuser,   // temp_missing
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // phase_value[18:0], stage[21:19], transition_event[24:22],
                                    // bbch_value[39:25]
   output logic [1:0]  rsp_tuser,   // bbch_valid, missing_status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   optr_pkg::optr_cfg_type cfg_ff, cfg_in;
   optr_pkg::optr_cmd_type cmd;
   optr_pkg::optr_sts_type sts;

   logic [18:0] phase_value;
   logic [2:0]  stage, transition_event;
   logic [14:0] bbch_value;
   logic        bbch_valid, missing_status;

   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            optr_pkg::REG_START_DAY: cfg_in.start_day = csr_data;
            optr_pkg::REG_FLOWER_DD: cfg_in.flower_dd = csr_data;
            optr_pkg::REG_RIPEN_DD:  cfg_in.ripen_dd  = csr_data;
            optr_pkg::REG_BBCH_EN:   cfg_in.bbch_en   = csr_data[0];
            default:                 cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_day <= optr_pkg::START_DAY_RST;
         cfg_ff.flower_dd <= optr_pkg::DD_LIMIT_RST;
         cfg_ff.ripen_dd  <= optr_pkg::DD_LIMIT_RST;
         cfg_ff.bbch_en   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   optr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   optr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .sts              (sts),
      .day_number       (req_tdata[15:0]),
      .min_temp         (req_tdata[26:16]),
      .max_temp         (req_tdata[37:27]),
      .temp_missing     (req_tuser[0]),
      .phase_value      (phase_value),
      .stage            (stage),
      .transition_event (transition_event),
      .bbch_value       (bbch_value),
      .bbch_valid       (bbch_valid),
      .missing_status   (missing_status)
   );

   assign rsp_tdata = {bbch_value, transition_event, stage, phase_value};
   assign rsp_tuser = {missing_status, bbch_valid};

endmodule

/* verif/testbench.sv */
// Self-checking testbench for olive_phenology_phase_tracker: a directed table of daily
// requests and register writes, then randomised seasons, every result scored against
// a phase predictor or a typed value. Depends on optr_pkg and the tracker RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import optr_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int INDUCT_SCALE = 850;   // 17 days times 50 twentieths

   localparam logic [IDX_W-1:0] REG_SPARE_LO = 8'd4;
   localparam logic [IDX_W-1:0] REG_SPARE_HI = 8'hFF;

   typedef logic [63:0] wide_t;

   localparam wide_t ONE_PHASE = wide_t'(1) << FRAC_BITS;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [2:0]         stage;
      logic [2:0]         evt;
      logic [14:0]        bbch;
      logic               bbch_ok;
      logic               skipped;
   } phase_report_t;

   typedef struct packed {
      logic               is_reg;
      logic [IDX_W-1:0]   idx;
      logic [15:0]        val;
      logic [15:0]        day;
      logic [10:0]        tmin;
      logic [10:0]        tmax;
      logic               miss;
      logic               typed;
      phase_report_t      want;
   } stim_row_t;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   int            rsp_stall_pct  = 0;
   int            rsp_hold_left  = 0;
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   wide_t         season_phase   = '0;
   optr_cfg_type  tracker_regs   = {START_DAY_RST, DD_LIMIT_RST, DD_LIMIT_RST, 1'b0};
   phase_report_t awaited_reports[$];
   stim_row_t     stim_rows[$];

   olive_phenology_phase_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_reports.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Moves the season on by one day and returns the result the tracker owes for it.
   function automatic phase_report_t advance_season(input logic [15:0] day,
                                                    input logic [10:0] tmin,
                                                    input logic [10:0] tmax,
                                                    input logic miss);
      phase_report_t r;
      logic [2:0]    stg;
      int            s, tn, tx, n;
      wide_t         gain, ceiling, lim, a, d, frac;
      r = '0;
      r.evt = EVT_NONE;
      tn = int'($signed(tmin));
      tx = int'($signed(tmax));
      stg = season_phase[FRAC_BITS+2:FRAC_BITS];
      if (!miss) begin
         s = tn + tx;
         ceiling = wide_t'(stg + 1) << FRAC_BITS;
         gain = '0;
         case (stg)
            STG_DORMANT: begin
               if (day == tracker_regs.start_day) begin
                  season_phase = ONE_PHASE;
                  r.evt = EVT_START;
               end
            end
            STG_INDUCTION: begin
               if (s >= 244 && s <= 266)
                  n = 50;
               else if (s >= 194 && s < 244 && tx >= 125)
                  n = s - 194;
               else if (s > 266 && s <= 316 && tx <= 211)
                  n = s - 266;
               else
                  n = 0;
               gain = (wide_t'(n) << FRAC_BITS) / INDUCT_SCALE;
            end
            STG_FLOWERING, STG_RIPENING: begin
               lim = (stg == STG_FLOWERING) ? tracker_regs.flower_dd : tracker_regs.ripen_dd;
               if (lim == 0)
                  lim = 1;
               if (s > 250) begin
                  gain = (wide_t'(s - 250) << FRAC_BITS) / (2 * lim);
               end else if (tx > 125) begin
                  // cool mean: triangle estimate of the time above the base
                  a = wide_t'(tx - 125);
                  d = wide_t'(tx - tn);
                  gain = ((a * a) << FRAC_BITS) / (2 * d * lim);
               end
            end
            default: ;
         endcase
         if (stg != STG_DORMANT && stg != STG_MATURE) begin
            season_phase = season_phase + gain;
            if (season_phase >= ceiling) begin
               season_phase = ceiling;
               r.evt = stg + 1;
            end
         end
         stg = season_phase[FRAC_BITS+2:FRAC_BITS];
      end
      frac = season_phase & (ONE_PHASE - 1);
      if (tracker_regs.bbch_en && stg != STG_DORMANT) begin
         r.bbch_ok = 1'b1;
         case (stg)
            STG_INDUCTION: r.bbch = 15'((9 * frac) >> (FRAC_BITS - 8));
            STG_FLOWERING: r.bbch = BBCH_FLOWER_BASE + 15'((56 * frac) >> (FRAC_BITS - 8));
            STG_RIPENING:  r.bbch = BBCH_RIPEN_BASE + 15'((24 * frac) >> (FRAC_BITS - 8));
            default:       r.bbch = BBCH_MATURE;
         endcase
      end
      r.phase = season_phase[PHASE_W-1:0];
      r.stage = stg;
      r.skipped = miss;
      return r;
   endfunction

   function automatic string describe(input phase_report_t r);
      return $sformatf("phase %0d stage %0d event %0d bbch %0d valid %0d skipped %0d",
                       r.phase, r.stage, r.evt, r.bbch, r.bbch_ok, r.skipped);
   endfunction

   function automatic void await_report(input phase_report_t r);
      awaited_reports.insert(awaited_reports.size(), r);
   endfunction

   function automatic void add_row(input stim_row_t r);
      stim_rows.insert(stim_rows.size(), r);
   endfunction

   task automatic score_report(input phase_report_t got);
      phase_report_t want;
      if (awaited_reports.size() == 0) begin
         if (mismatch_count < 10)
            $display("unrequested result at cycle %0d: %s", cycle_count, describe(got));
         mismatch_count++;
      end else begin
         want = awaited_reports.pop_front();
         if (got !== want) begin
            if (mismatch_count < 10) begin
               $display("result mismatch at cycle %0d", cycle_count);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         score_report({rsp_tdata[18:0], rsp_tdata[21:19], rsp_tdata[24:22],
                       rsp_tdata[39:25], rsp_tuser[0], rsp_tuser[1]});
   end

   // long hold-off first, random stalls otherwise
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic send_item(input logic [15:0] day, input logic [10:0] tmin,
                            input logic [10:0] tmax, input logic miss,
                            input logic typed, input phase_report_t want);
      phase_report_t predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, tmax, tmin, day};
      req_tuser  <= miss;
      do @(posedge clock); while (!req_tready);
      predicted = advance_season(day, tmin, tmax, miss);
      if (typed)
         predicted = want;
      await_report(predicted);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_START_DAY: tracker_regs.start_day = val;
         REG_FLOWER_DD: tracker_regs.flower_dd = val;
         REG_RIPEN_DD:  tracker_regs.ripen_dd = val;
         REG_BBCH_EN:   tracker_regs.bbch_en = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Weather shaped to the current stage so the season keeps moving; the rest is noise.
   task automatic send_random();
      int         roll, tn, tx, s;
      logic [2:0] stg;
      logic       miss;
      stg = season_phase[FRAC_BITS+2:FRAC_BITS];
      roll = $urandom_range(99);
      miss = (roll < 8);
      tn = span(-1024, 1023);
      tx = span(-1024, 1023);
      if (roll >= 25) begin
         case (stg)
            STG_INDUCTION: begin
               s  = span(184, 326);
               tx = span(110, 225);
               tn = s - tx;
            end
            STG_FLOWERING, STG_RIPENING: begin
               case ($urandom_range(2))
                  0: begin
                     tx = span(126, 1000);
                     tn = tx - span(0, 400);
                  end
                  1: begin
                     tx = span(126, 600);
                     tn = span(-600, 250 - tx);
                  end
                  default: begin
                     tx = span(-600, 125);
                     tn = span(-600, tx);
                  end
               endcase
            end
            default: begin
               tx = span(-600, 600);
               tn = span(-600, 600);
            end
         endcase
      end
      send_item(16'($urandom_range(65535)), 11'(tn), 11'(tx), miss, 1'b0, '0);
   endtask

   task automatic run_season(input int count, input int idle_pct, input int stall_pct);
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         if ($urandom_range(99) < idle_pct)
            idle_sender($urandom_range(60, 1));
         send_random();
      end
   endtask

   function automatic stim_row_t reg_row(input logic [IDX_W-1:0] idx, input logic [15:0] val);
      stim_row_t r;
      r = '0;
      r.is_reg = 1'b1;
      r.idx = idx;
      r.val = val;
      return r;
   endfunction

   function automatic stim_row_t day_row(input logic [15:0] day, input int tmin,
                                         input int tmax, input logic miss);
      stim_row_t r;
      r = '0;
      r.day  = day;
      r.tmin = 11'(tmin);
      r.tmax = 11'(tmax);
      r.miss = miss;
      return r;
   endfunction

   function automatic stim_row_t known_row(input logic [15:0] day, input int tmin,
                                           input int tmax, input logic miss,
                                           input phase_report_t want);
      stim_row_t r;
      r = day_row(day, tmin, tmax, miss);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset state: season opens on day 0, BBCH off
      add_row(known_row(16'd7, 0, 0, 1'b0,
                        {19'd0, STG_DORMANT, EVT_NONE, 15'd0, 1'b0, 1'b0}));
      add_row(reg_row(REG_START_DAY, 16'hFFFF));
      add_row(reg_row(REG_BBCH_EN, 16'h0001));
      add_row(reg_row(REG_SPARE_LO, 16'h0000));
      add_row(reg_row(REG_SPARE_HI, 16'h0000));
      add_row(known_row(16'd0, -1024, 1023, 1'b0,
                        {19'd0, STG_DORMANT, EVT_NONE, 15'd0, 1'b0, 1'b0}));
      add_row(known_row(16'hFFFE, 600, 600, 1'b0,
                        {19'd0, STG_DORMANT, EVT_NONE, 15'd0, 1'b0, 1'b0}));
      // start day with temperature missing: season must not open
      add_row(known_row(16'hFFFF, -600, -600, 1'b1,
                        {19'd0, STG_DORMANT, EVT_NONE, 15'd0, 1'b0, 1'b1}));
      add_row(known_row(16'hFFFF, 1023, -1024, 1'b0,
                        {19'd65536, STG_INDUCTION, EVT_START, 15'd0, 1'b1, 1'b0}));
      // induction window edges
      add_row(day_row(16'd0, 125, 125, 1'b0));
      add_row(day_row(16'd1, 69, 125, 1'b0));
      add_row(day_row(16'd2, 118, 125, 1'b0));
      add_row(day_row(16'd3, 119, 124, 1'b0));
      add_row(day_row(16'd4, 33, 211, 1'b0));
      add_row(day_row(16'd5, 56, 211, 1'b0));
      add_row(day_row(16'd6, 105, 211, 1'b0));
      add_row(day_row(16'd7, 106, 211, 1'b0));
      add_row(day_row(16'd8, 88, 212, 1'b0));
      add_row(day_row(16'd9, 140, 126, 1'b0));
      add_row(day_row(16'd10, 125, 125, 1'b1));
      add_row(day_row(16'd11, -1024, -1024, 1'b0));
      add_row(day_row(16'd12, 1023, 1023, 1'b0));
      add_row(reg_row(REG_BBCH_EN, 16'hFFFE));
      add_row(day_row(16'd13, 125, 125, 1'b0));

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_reg)
            write_reg(stim_rows[i].idx, stim_rows[i].val);
         else
            send_item(stim_rows[i].day, stim_rows[i].tmin, stim_rows[i].tmax,
                      stim_rows[i].miss, stim_rows[i].typed, stim_rows[i].want);
      end

      // slowest limits: induction and most of flowering
      write_reg(REG_FLOWER_DD, 16'hFFFF);
      write_reg(REG_RIPEN_DD, 16'hFFFF);
      write_reg(REG_BBCH_EN, 16'h0001);
      run_season(500, 0, 0);

      // zero flowering limit counts as 1, so one warm day can close the stage
      write_reg(REG_FLOWER_DD, 16'h0000);
      write_reg(REG_START_DAY, 16'h0000);
      run_season(450, 47, 0);

      write_reg(REG_RIPEN_DD, 16'h0000);
      write_reg(REG_FLOWER_DD, 16'h0001);
      write_reg(REG_BBCH_EN, 16'h0000);
      run_season(300, 0, 47);

      write_reg(REG_FLOWER_DD, DD_LIMIT_RST);
      write_reg(REG_RIPEN_DD, 16'h0001);
      write_reg(REG_BBCH_EN, 16'hFFFF);
      run_season(300, 29, 29);

      // backpressure: results held back while requests keep coming
      rsp_hold_left = 600;
      run_season(150, 0, 0);
      drain();
      run_season(250, 29, 29);

      drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && awaited_reports.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
